/* hw/rtl/rws_pkg.sv */
package rws_pkg;

	localparam int MAX_POPULATION = 256;

	localparam int FUNC_W   = 2;
	localparam int FIT_IN_W = 16;
	localparam int FRAC_W   = 16;
	localparam int CHOSEN_W = 8;
	localparam int STATUS_W = 2;
	localparam int LOADED_W = 9;

	localparam int IDX_W  = $clog2(MAX_POPULATION);
	localparam int CNT_W  = $clog2(MAX_POPULATION + 1);
	localparam int FIT_W  = 15;
	localparam int TOT_W  = FIT_W + IDX_W;
	localparam int PROD_W = FRAC_W + TOT_W;

	localparam logic [FUNC_W-1:0] FUNC_LOAD  = 2'd0;
	localparam logic [FUNC_W-1:0] FUNC_DRAW  = 2'd1;
	localparam logic [FUNC_W-1:0] FUNC_CLEAR = 2'd2;

	localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
	localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
	localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

	typedef struct packed {
		logic take;
		logic mul;
		logic step;
		logic emit;
	} cmd_t;

	typedef struct packed {
		logic draw_go;
		logic scan_done;
	} sts_t;

endpackage

/* hw/rtl/rws_req_if.sv */
interface rws_req_if;
	logic                                   valid;
	logic                                   ready;
	logic [rws_pkg::FUNC_W-1:0]             func;
	logic signed [rws_pkg::FIT_IN_W-1:0]    fitness_value;
	logic [rws_pkg::FRAC_W-1:0]             random_fraction;

	modport source (output valid, func, fitness_value, random_fraction, input ready);
	modport sink (input valid, func, fitness_value, random_fraction, output ready);
endinterface

/* hw/rtl/rws_rsp_if.sv */
interface rws_rsp_if;
	logic                           valid;
	logic                           ready;
	logic [rws_pkg::CHOSEN_W-1:0]   chosen_index;
	logic [rws_pkg::STATUS_W-1:0]   status;
	logic [rws_pkg::LOADED_W-1:0]   loaded_count;

	modport source (output valid, chosen_index, status, loaded_count, input ready);
	modport sink (input valid, chosen_index, status, loaded_count, output ready);
endinterface

/* hw/rtl/rws_ram.sv */
module rws_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

/* hw/rtl/rws_ctrl.sv */
module rws_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_ready,
	output logic           rsp_valid,
	input  logic           rsp_ready,
	input  rws_pkg::sts_t  sts,
	output rws_pkg::cmd_t  cmd
);

	typedef enum logic [3:0] {
		S_IDLE = 4'b0001,
		S_MUL  = 4'b0010,
		S_SCAN = 4'b0100,
		S_RESP = 4'b1000
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   out_valid_q;
	logic   slot_free;

	assign req_ready = (state_q == S_IDLE);
	assign rsp_valid = out_valid_q;
	assign slot_free = !out_valid_q || rsp_ready;

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					cmd.take = 1'b1;
					state_d  = sts.draw_go ? S_MUL : S_RESP;
				end
			end
			S_MUL: begin
				cmd.mul = 1'b1;
				state_d = S_SCAN;
			end
			S_SCAN: begin
				cmd.step = 1'b1;
				if (sts.scan_done) begin
					state_d = S_RESP;
				end
			end
			S_RESP: begin
				if (slot_free) begin
					cmd.emit = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

/* hw/rtl/rws_dpath.sv */
module rws_dpath (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  rws_pkg::cmd_t                         cmd,
	output rws_pkg::sts_t                         sts,
	input  logic [rws_pkg::FUNC_W-1:0]            func,
	input  logic signed [rws_pkg::FIT_IN_W-1:0]   fitness_value,
	input  logic [rws_pkg::FRAC_W-1:0]            random_fraction,
	output logic [rws_pkg::CHOSEN_W-1:0]          chosen_index,
	output logic [rws_pkg::STATUS_W-1:0]          status,
	output logic [rws_pkg::LOADED_W-1:0]          loaded_count
);

	logic [rws_pkg::CNT_W-1:0]    count_q;
	logic [rws_pkg::TOT_W-1:0]    total_q;
	logic [rws_pkg::FRAC_W-1:0]   frac_q;
	logic [rws_pkg::TOT_W-1:0]    thresh_q;
	logic [rws_pkg::TOT_W-1:0]    acc_q;
	logic [rws_pkg::IDX_W-1:0]    idx_q;
	logic [rws_pkg::IDX_W-1:0]    res_idx_q;
	logic [rws_pkg::STATUS_W-1:0] res_sts_q;
	logic [rws_pkg::CHOSEN_W-1:0] chosen_q;
	logic [rws_pkg::STATUS_W-1:0] status_q;
	logic [rws_pkg::LOADED_W-1:0] loaded_q;

	logic [rws_pkg::FIT_W-1:0]    fit_clamped;
	logic                         full;
	logic                         ram_we;
	logic [rws_pkg::IDX_W-1:0]    raddr;
	logic [rws_pkg::FIT_W-1:0]    rdata;
	logic [rws_pkg::TOT_W-1:0]    acc_next;
	logic                         hit;
	logic                         last;
	logic [rws_pkg::PROD_W-1:0]   prod;

	// negative fitness counts as one
	assign fit_clamped = fitness_value[rws_pkg::FIT_IN_W-1] ? rws_pkg::FIT_W'(1)
		: fitness_value[rws_pkg::FIT_W-1:0];
	assign full   = (count_q == rws_pkg::CNT_W'(rws_pkg::MAX_POPULATION));
	assign ram_we = cmd.take && (func == rws_pkg::FUNC_LOAD) && !full;

	// read one entry ahead: entry 0 during the multiply, then the next index
	assign raddr    = cmd.step ? idx_q + rws_pkg::IDX_W'(1) : '0;
	assign acc_next = acc_q + rws_pkg::TOT_W'(rdata);
	assign hit      = (acc_next >= thresh_q);
	assign last     = (rws_pkg::CNT_W'(idx_q) == count_q - rws_pkg::CNT_W'(1));
	assign prod     = rws_pkg::PROD_W'(frac_q) * rws_pkg::PROD_W'(total_q);

	assign sts.draw_go   = (func == rws_pkg::FUNC_DRAW) && (count_q != '0);
	assign sts.scan_done = hit || last;

	assign chosen_index = chosen_q;
	assign status       = status_q;
	assign loaded_count = loaded_q;

	rws_ram #(
		.WIDTH (rws_pkg::FIT_W),
		.DEPTH (rws_pkg::MAX_POPULATION)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (count_q[rws_pkg::IDX_W-1:0]),
		.wdata (fit_clamped),
		.raddr (raddr),
		.rdata (rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			total_q <= '0;
		end else if (cmd.take) begin
			case (func)
				rws_pkg::FUNC_LOAD: begin
					if (!full) begin
						count_q <= count_q + rws_pkg::CNT_W'(1);
						total_q <= total_q + rws_pkg::TOT_W'(fit_clamped);
					end
				end
				rws_pkg::FUNC_CLEAR: begin
					count_q <= '0;
					total_q <= '0;
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.take) begin
			frac_q    <= random_fraction;
			res_idx_q <= '0;
			if (func == rws_pkg::FUNC_LOAD && full) begin
				res_sts_q <= rws_pkg::ST_FULL;
			end else if (func == rws_pkg::FUNC_DRAW && count_q == '0) begin
				res_sts_q <= rws_pkg::ST_EMPTY;
			end else begin
				res_sts_q <= rws_pkg::ST_OK;
			end
		end
		if (cmd.mul) begin
			thresh_q <= prod[rws_pkg::PROD_W-1:rws_pkg::FRAC_W];
			acc_q    <= '0;
			idx_q    <= '0;
		end
		if (cmd.step) begin
			acc_q <= acc_next;
			idx_q <= idx_q + rws_pkg::IDX_W'(1);
			if (hit) begin
				res_idx_q <= idx_q;
			end
		end
		if (cmd.emit) begin
			chosen_q <= rws_pkg::CHOSEN_W'(res_idx_q);
			status_q <= res_sts_q;
			loaded_q <= rws_pkg::LOADED_W'(count_q);
		end
	end

endmodule

/* hw/rtl/roulette_wheel_selector.sv */
// fitness-proportional parent selector
// req channel carries func, fitness_value and random_fraction; rsp channel returns
// chosen_index, status and loaded_count, one rsp item for every req item.
// a load appends the clamped fitness to a 256-entry store and adds it to the total;
// a clear empties the store; a draw scales the fraction by the total and scans the
// store for the first entry whose running sum reaches that threshold.
// one item is worked on at a time. a load, a clear, an unused code or a draw from an
// empty store goes from the accepting cycle straight to the hand-over, which moves the
// result into the output register once that register is free.
// a draw that picks entry k goes from the accepting cycle to the multiply, then scans
// entries 0 to k (one store read per cycle through the registered ram port) and then
// hands over the same way.
// the result sits in an output register; req is taken again as soon as the result
// has been moved there, and it waits there while rsp.ready is low. a following item
// that finishes meanwhile is held back and req.ready stays low until it moves on.
// reset empties the store and clears the total; no clearing pass is needed, the
// scan only reads entries below the count.
module roulette_wheel_selector (
	input logic     clk,
	input logic     arst_n,
	rws_req_if.sink req,
	rws_rsp_if.source rsp
);

	rws_pkg::cmd_t cmd;
	rws_pkg::sts_t sts;

	rws_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.rsp_valid (rsp.valid),
		.rsp_ready (rsp.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	rws_dpath u_dpath (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.sts             (sts),
		.func            (req.func),
		.fitness_value   (req.fitness_value),
		.random_fraction (req.random_fraction),
		.chosen_index    (rsp.chosen_index),
		.status          (rsp.status),
		.loaded_count    (rsp.loaded_count)
	);

`ifndef SYNTH
	a_busy_after_take: assert property (@(posedge clk) disable iff (!arst_n)
		req.valid && req.ready |=> !req.ready)
		else $error("req taken again right after an item");

	a_empty_index: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.status == rws_pkg::ST_EMPTY |-> rsp.chosen_index == '0)
		else $error("empty draw returned a nonzero index");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid |-> rsp.loaded_count <= rws_pkg::LOADED_W'(rws_pkg::MAX_POPULATION))
		else $error("loaded count beyond store depth");

	a_index_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.status == rws_pkg::ST_OK && rsp.chosen_index != '0
		|-> rws_pkg::LOADED_W'(rsp.chosen_index) < rsp.loaded_count)
		else $error("chosen index outside loaded entries");
`endif

endmodule

/* tb/sv/tb_roulette_wheel_selector.sv */
module tb_roulette_wheel_selector;
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [rws_pkg::FUNC_W-1:0] FUNC_UNUSED = 2'd3;
	localparam int CYCLE_LIMIT = 2_000_000;
	localparam int HOLD_CYCLES = 300;
	localparam int ITEMS_PER_PHASE = 500;
	localparam int NUM_DIRECTED = 22;

	typedef struct packed {
		logic [rws_pkg::CHOSEN_W-1:0] idx;
		logic [rws_pkg::STATUS_W-1:0] st;
		logic [rws_pkg::LOADED_W-1:0] cnt;
	} pick_result_t;

	typedef struct packed {
		logic [rws_pkg::FUNC_W-1:0]          func;
		logic signed [rws_pkg::FIT_IN_W-1:0] fit;
		logic [rws_pkg::FRAC_W-1:0]          frac;
		logic                                typed;
		logic [rws_pkg::CHOSEN_W-1:0]        idx;
		logic [rws_pkg::STATUS_W-1:0]        st;
		logic [rws_pkg::LOADED_W-1:0]        cnt;
	} stim_row_t;

	// rows with typed = 0 are checked against the wheel predictor only
	localparam stim_row_t DIRECTED_ROWS [NUM_DIRECTED] = '{
		'{rws_pkg::FUNC_DRAW,  16'sh0000, 16'h1234, 1'b1, 8'd0, rws_pkg::ST_EMPTY, 9'd0},
		'{FUNC_UNUSED,         16'sh0000, 16'h0000, 1'b1, 8'd0, rws_pkg::ST_OK,    9'd0},
		'{rws_pkg::FUNC_CLEAR, 16'sh0000, 16'h0000, 1'b1, 8'd0, rws_pkg::ST_OK,    9'd0},
		'{rws_pkg::FUNC_LOAD,  16'sh0000, 16'h0000, 1'b1, 8'd0, rws_pkg::ST_OK,    9'd1},
		'{rws_pkg::FUNC_LOAD,  16'sh0000, 16'hFFFF, 1'b1, 8'd0, rws_pkg::ST_OK,    9'd2},
		'{rws_pkg::FUNC_DRAW,  16'sh0000, 16'hFFFF, 1'b1, 8'd0, rws_pkg::ST_OK,    9'd2},
		'{rws_pkg::FUNC_LOAD,  16'sh8000, 16'h0000, 1'b1, 8'd0, rws_pkg::ST_OK,    9'd3},
		'{rws_pkg::FUNC_LOAD,  16'shFFFF, 16'h0000, 1'b1, 8'd0, rws_pkg::ST_OK,    9'd4},
		'{rws_pkg::FUNC_LOAD,  16'sh7FFF, 16'h0000, 1'b1, 8'd0, rws_pkg::ST_OK,    9'd5},
		'{rws_pkg::FUNC_LOAD,  16'sh5555, 16'hAAAA, 1'b1, 8'd0, rws_pkg::ST_OK,    9'd6},
		'{rws_pkg::FUNC_DRAW,  16'shFFFF, 16'h0000, 1'b1, 8'd0, rws_pkg::ST_OK,    9'd6},
		'{rws_pkg::FUNC_DRAW,  16'sh0000, 16'hFFFF, 1'b0, 8'd0, rws_pkg::ST_OK,    9'd0},
		'{rws_pkg::FUNC_DRAW,  16'sh0000, 16'h8000, 1'b0, 8'd0, rws_pkg::ST_OK,    9'd0},
		'{rws_pkg::FUNC_DRAW,  16'sh0000, 16'h0001, 1'b0, 8'd0, rws_pkg::ST_OK,    9'd0},
		'{rws_pkg::FUNC_DRAW,  16'sh0000, 16'hAAAA, 1'b0, 8'd0, rws_pkg::ST_OK,    9'd0},
		'{rws_pkg::FUNC_LOAD,  16'sh0001, 16'h5555, 1'b0, 8'd0, rws_pkg::ST_OK,    9'd0},
		'{rws_pkg::FUNC_DRAW,  16'sh0000, 16'h7FFF, 1'b0, 8'd0, rws_pkg::ST_OK,    9'd0},
		'{FUNC_UNUSED,         16'shFFFF, 16'hFFFF, 1'b1, 8'd0, rws_pkg::ST_OK,    9'd7},
		'{rws_pkg::FUNC_CLEAR, 16'shFFFF, 16'hFFFF, 1'b1, 8'd0, rws_pkg::ST_OK,    9'd0},
		'{rws_pkg::FUNC_DRAW,  16'sh0000, 16'hFFFF, 1'b1, 8'd0, rws_pkg::ST_EMPTY, 9'd0},
		'{rws_pkg::FUNC_LOAD,  16'sh7FFF, 16'h0000, 1'b1, 8'd0, rws_pkg::ST_OK,    9'd1},
		'{rws_pkg::FUNC_DRAW,  16'sh0000, 16'hFFFF, 1'b1, 8'd0, rws_pkg::ST_OK,    9'd1}
	};

	logic clk;
	logic arst_n;

	rws_req_if req_ch ();
	rws_rsp_if rsp_ch ();

	roulette_wheel_selector u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	// predictor state
	logic [rws_pkg::FIT_W-1:0] fit_mem [rws_pkg::MAX_POPULATION];
	int                        pop_count = 0;
	logic [rws_pkg::TOT_W-1:0] fit_sum = '0;

	pick_result_t pending_picks [$];
	pick_result_t want_pick;
	pick_result_t typed_pick;

	int  errors = 0;
	int  cycle_count = 0;
	int  random_items = 0;
	int  n_loads = 0, n_full = 0, n_draws = 0, n_empty = 0, n_clears = 0, n_unused = 0;
	int  tx_idle_pct = 0;
	int  rx_idle_pct = 0;
	bit  hold_kick = 1'b0;
	bit  hold_kick_q = 1'b0;
	int  hold_left = 0;

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("tb_roulette_wheel_selector NOT OK");
			$finish;
		end
	end

	// long receiver hold-off, counted here so the sender keeps offering meanwhile
	always @(posedge clk) begin
		if (hold_kick != hold_kick_q) begin
			hold_kick_q <= hold_kick;
			hold_left   <= HOLD_CYCLES;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
		end
	end

	always @(posedge clk) begin
		if (!arst_n) begin
			rsp_ch.ready <= 1'b0;
		end else begin
			rsp_ch.ready <= (hold_left == 0) && ($urandom_range(99) >= rx_idle_pct);
		end
	end

	always @(posedge clk) begin
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			if (pending_picks.size() == 0) begin
				$error("result item with nothing pending");
				errors++;
			end else begin
				want_pick = pending_picks.pop_front();
				if (rsp_ch.chosen_index !== want_pick.idx) begin
					$error("chosen_index expected %0d got %0d", want_pick.idx,
						rsp_ch.chosen_index);
					errors++;
				end
				if (rsp_ch.status !== want_pick.st) begin
					$error("status expected %0d got %0d", want_pick.st, rsp_ch.status);
					errors++;
				end
				if (rsp_ch.loaded_count !== want_pick.cnt) begin
					$error("loaded_count expected %0d got %0d", want_pick.cnt,
						rsp_ch.loaded_count);
					errors++;
				end
			end
		end
	end

	function automatic pick_result_t select_parent(input logic [rws_pkg::FUNC_W-1:0] f,
			input logic signed [rws_pkg::FIT_IN_W-1:0] fv,
			input logic [rws_pkg::FRAC_W-1:0] rf);
		pick_result_t               r;
		logic [rws_pkg::FIT_W-1:0]  clamped;
		logic [rws_pkg::PROD_W-1:0] thr;
		logic [rws_pkg::TOT_W:0]    acc;
		bit                         found;
		r = '0;
		case (f)
			rws_pkg::FUNC_LOAD: begin
				if (pop_count >= rws_pkg::MAX_POPULATION) begin
					r.st = rws_pkg::ST_FULL;
					n_full++;
				end else begin
					// negative fitness counts as 1
					clamped = fv[rws_pkg::FIT_IN_W-1] ? rws_pkg::FIT_W'(1)
						: fv[rws_pkg::FIT_W-1:0];
					fit_mem[pop_count] = clamped;
					pop_count++;
					fit_sum += clamped;
					n_loads++;
				end
			end
			rws_pkg::FUNC_DRAW: begin
				if (pop_count == 0) begin
					r.st = rws_pkg::ST_EMPTY;
					n_empty++;
				end else begin
					thr = (rws_pkg::PROD_W'(rf) * rws_pkg::PROD_W'(fit_sum))
						>> rws_pkg::FRAC_W;
					acc = '0;
					found = 1'b0;
					for (int i = 0; i < pop_count; i++) begin
						acc += fit_mem[i];
						if (!found && rws_pkg::PROD_W'(acc) >= thr) begin
							found = 1'b1;
							r.idx = rws_pkg::CHOSEN_W'(i);
						end
					end
					n_draws++;
				end
			end
			rws_pkg::FUNC_CLEAR: begin
				pop_count = 0;
				fit_sum = '0;
				n_clears++;
			end
			default: n_unused++;
		endcase
		r.cnt = rws_pkg::LOADED_W'(pop_count);
		return r;
	endfunction

	task automatic offer_item(input logic [rws_pkg::FUNC_W-1:0] f,
			input logic signed [rws_pkg::FIT_IN_W-1:0] fv,
			input logic [rws_pkg::FRAC_W-1:0] rf, input bit typed,
			input pick_result_t typed_res);
		int           gap;
		pick_result_t r;
		gap = 0;
		while ($urandom_range(99) < tx_idle_pct)
			gap++;
		if (gap > 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_ch.valid           <= 1'b1;
		req_ch.func            <= f;
		req_ch.fitness_value   <= fv;
		req_ch.random_fraction <= rf;
		do @(posedge clk); while (!req_ch.ready);
		r = select_parent(f, fv, rf);
		pending_picks.push_back(typed ? typed_res : r);
	endtask

	function automatic logic signed [rws_pkg::FIT_IN_W-1:0] rand_fitness();
		case ($urandom_range(7))
			0, 1: return rws_pkg::FIT_IN_W'($urandom);
			2: return {1'b1, 15'($urandom)};
			3: return '0;
			4, 5: return rws_pkg::FIT_IN_W'($urandom_range(15));
			6: return 16'sh7FFF;
			default: return rws_pkg::FIT_IN_W'($urandom_range(300));
		endcase
	endfunction

	function automatic logic [rws_pkg::FRAC_W-1:0] rand_fraction();
		case ($urandom_range(5))
			0: return '0;
			1: return '1;
			default: return rws_pkg::FRAC_W'($urandom);
		endcase
	endfunction

	// one population: optional clear, loads with draws and unused codes mixed in, then a few draws
	task automatic run_episode(input int target);
		int loads_left;
		if ($urandom_range(3) != 0) begin
			offer_item(rws_pkg::FUNC_CLEAR, rws_pkg::FIT_IN_W'($urandom),
				rws_pkg::FRAC_W'($urandom), 1'b0, '0);
			random_items++;
		end
		loads_left = target;
		while (loads_left > 0) begin
			if ($urandom_range(32) == 0) begin
				offer_item(FUNC_UNUSED, rws_pkg::FIT_IN_W'($urandom),
					rws_pkg::FRAC_W'($urandom), 1'b0, '0);
			end else if ($urandom_range(4) == 0) begin
				offer_item(rws_pkg::FUNC_DRAW, rws_pkg::FIT_IN_W'($urandom),
					rand_fraction(), 1'b0, '0);
				random_items++;
			end else begin
				offer_item(rws_pkg::FUNC_LOAD, rand_fitness(),
					rws_pkg::FRAC_W'($urandom), 1'b0, '0);
				loads_left--;
				random_items++;
			end
		end
		repeat ($urandom_range(1, 6)) begin
			offer_item(rws_pkg::FUNC_DRAW, rws_pkg::FIT_IN_W'($urandom), rand_fraction(),
				1'b0, '0);
			random_items++;
		end
	endtask

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		req_ch.valid <= 1'b0;
		req_ch.func <= rws_pkg::FUNC_CLEAR;
		req_ch.fitness_value <= '0;
		req_ch.random_fraction <= '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		tx_idle_pct = 11;
		rx_idle_pct <= 48;
		@(posedge clk);

		for (int i = 0; i < NUM_DIRECTED; i++) begin
			typed_pick.idx = DIRECTED_ROWS[i].idx;
			typed_pick.st  = DIRECTED_ROWS[i].st;
			typed_pick.cnt = DIRECTED_ROWS[i].cnt;
			offer_item(DIRECTED_ROWS[i].func, DIRECTED_ROWS[i].fit, DIRECTED_ROWS[i].frac,
				DIRECTED_ROWS[i].typed, typed_pick);
		end

		for (int phase = 0; phase < 3; phase++) begin
			case (phase)
				0: begin
					tx_idle_pct = 11;
					rx_idle_pct <= 48;
				end
				1: begin
					tx_idle_pct = 48;
					rx_idle_pct <= 11;
				end
				default: begin
					tx_idle_pct = 0;
					rx_idle_pct <= 0;
				end
			endcase
			if (phase != 1)
				hold_kick <= ~hold_kick;
			// overfill once so that loads into a full store are seen early
			if (phase == 0)
				run_episode(rws_pkg::MAX_POPULATION + 4);
			while (random_items < (phase + 1) * ITEMS_PER_PHASE)
				run_episode(($urandom_range(9) == 0) ? $urandom_range(240, 270)
					: $urandom_range(1, 24));
		end
		req_ch.valid <= 1'b0;

		while (pending_picks.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);

		$display("covered %0d loads (%0d into a full store), %0d draws (%0d from an empty store)",
			n_loads, n_full, n_draws, n_empty);
		$display("plus %0d clears and %0d unused codes; %0d mismatches", n_clears, n_unused,
			errors);
		if (errors == 0 && pending_picks.size() == 0) begin
			$display("tb_roulette_wheel_selector OK");
		end else begin
			$display("tb_roulette_wheel_selector NOT OK");
		end
		$finish;
	end

endmodule

/* roulette_wheel_selector.f */
hw/rtl/rws_pkg.sv
hw/rtl/rws_req_if.sv
hw/rtl/rws_rsp_if.sv
hw/rtl/rws_ram.sv
hw/rtl/rws_ctrl.sv
hw/rtl/rws_dpath.sv
hw/rtl/roulette_wheel_selector.sv
tb/sv/tb_roulette_wheel_selector.sv
